[hw/rtl/bra_pkg.sv]
// shared constants and types for the bucket run allocator
package bra_pkg;

    // capacity and field widths
    localparam int MAX_BUCKETS = 4096;
    localparam int IDX_W       = $clog2(MAX_BUCKETS);
    localparam int CNT_W       = IDX_W + 1;

    // request codes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_SET     = 2'd2;

    // bucket state codes
    localparam logic [2:0] ST_FREE        = 3'd0;
    localparam logic [2:0] ST_DOWNLOADING = 3'd1;
    localparam logic [2:0] ST_DOWNLOADED  = 3'd4;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_REL,
        S_SET_RD,
        S_SET_WR,
        S_DONE
    } t_state;

endpackage

[hw/rtl/bucket_run_allocator.sv]
// bucket state store with first-fit / longest-run allocator and a sequencer
//
// channel  direction  handshake                    payload
// in       input      i_in_valid / o_in_ready      i_op i_bucket i_range_last i_new_state
//                                                  i_length_hint
// out      output     o_out_valid / i_out_ready    o_run_start o_run_length o_done_count
//                                                  o_all_done
// cfg      input      i_cfg_we                     i_cfg_data (bucket_count)
//
// one bucket per cycle through one write port and one registered read port of the
// state memory: allocate scans up to min(bucket_count, 4096) buckets and marks the
// run_length buckets of the chosen run, release walks the clipped range, set reads
// then writes the bucket, and each then loads the result register. after reset a
// clearing pass over all 4096 buckets runs before the first item is taken. a stalled
// result holds the sequencer in its final state; the input side is not ready until the item is finished.
module bucket_run_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bra_pkg::CNT_W-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_op,
    input  logic [bra_pkg::IDX_W-1:0]    i_bucket,
    input  logic [bra_pkg::IDX_W-1:0]    i_range_last,
    input  logic [2:0]                   i_new_state,
    input  logic [bra_pkg::CNT_W-1:0]    i_length_hint,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [bra_pkg::IDX_W-1:0]    o_run_start,
    output logic [bra_pkg::CNT_W-1:0]    o_run_length,
    output logic [bra_pkg::CNT_W-1:0]    o_done_count,
    output logic                         o_all_done
);

    localparam int IW = bra_pkg::IDX_W;
    localparam int CW = bra_pkg::CNT_W;

    bra_pkg::t_state r_state, n_state;

    // configuration
    logic [CW-1:0] r_bucket_count;
    logic [CW-1:0] w_used;

    // latched request
    logic [1:0]    r_op, n_op;
    logic [IW-1:0] r_bucket, n_bucket;
    logic [2:0]    r_nst, n_nst;
    logic [CW-1:0] r_hint, n_hint;

    // sequencer datapath
    logic [CW-1:0] r_addr, n_addr;
    logic [CW-1:0] r_end, n_end;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_pend, n_pend;
    logic [IW-1:0] r_pidx, n_pidx;
    logic [IW-1:0] r_cur_s, n_cur_s;
    logic [CW-1:0] r_cur_l, n_cur_l;
    logic [IW-1:0] r_best_s, n_best_s;
    logic [CW-1:0] r_best_l, n_best_l;
    logic [IW-1:0] r_rs, n_rs;
    logic [CW-1:0] r_rl, n_rl;
    logic [CW-1:0] r_total, n_total;

    // result register
    logic          r_out_valid, n_out_valid;
    logic [IW-1:0] r_o_start, n_o_start;
    logic [CW-1:0] r_o_len, n_o_len;
    logic [CW-1:0] r_o_done, n_o_done;
    logic          r_o_all, n_o_all;

    // state memory
    logic [2:0]    r_mem [bra_pkg::MAX_BUCKETS];
    logic [2:0]    r_rdata;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [2:0]    mem_wdata;
    logic [IW-1:0] mem_raddr;

    // handshake and scan decisions
    logic          w_accept;
    logic          w_set_ok;
    logic          w_slot_free;
    logic          w_free;
    logic [CW-1:0] w_cur_l_inc;
    logic          w_hit;
    logic          w_better;
    logic          w_scan_issue;
    logic          w_scan_fin;
    logic          w_rel_issue;
    logic          w_rel_fin;
    logic [CW-1:0] w_last_p1;

    // buckets in use, saturated to capacity
    assign w_used = (r_bucket_count > CW'(bra_pkg::MAX_BUCKETS)) ?
                    CW'(bra_pkg::MAX_BUCKETS) : r_bucket_count;

    assign o_in_ready  = (r_state == bra_pkg::S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_set_ok    = ({1'b0, i_bucket} < w_used) && (i_new_state <= bra_pkg::ST_DOWNLOADED);
    assign w_last_p1   = {1'b0, i_range_last} + CW'(1);

    // shared run counter and compare for the allocate scan
    assign w_free       = r_pend && (r_rdata == bra_pkg::ST_FREE);
    assign w_cur_l_inc  = r_cur_l + CW'(1);
    assign w_hit        = w_free && (w_cur_l_inc == r_hint);
    assign w_better     = w_free && (w_cur_l_inc > r_best_l);
    assign w_scan_issue = (r_addr < w_used) && !w_hit;
    assign w_scan_fin   = (r_addr >= w_used) && !r_pend;

    // release range walk
    assign w_rel_issue = (r_addr < r_end);
    assign w_rel_fin   = !w_rel_issue && !r_pend;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bra_pkg::S_CLEAR: begin
                if (r_addr[IW-1:0] == IW'(bra_pkg::MAX_BUCKETS - 1)) n_state = bra_pkg::S_IDLE;
            end
            bra_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_op)
                        bra_pkg::OP_ALLOC:   n_state = bra_pkg::S_SCAN;
                        bra_pkg::OP_RELEASE: n_state = bra_pkg::S_REL;
                        bra_pkg::OP_SET:     n_state = w_set_ok ? bra_pkg::S_SET_RD
                                                                : bra_pkg::S_DONE;
                        default:             n_state = bra_pkg::S_DONE;
                    endcase
                end
            end
            bra_pkg::S_SCAN: begin
                if (w_hit || w_scan_fin) n_state = bra_pkg::S_MARK;
            end
            bra_pkg::S_MARK: begin
                if (r_cnt == '0) n_state = bra_pkg::S_DONE;
            end
            bra_pkg::S_REL: begin
                if (w_rel_fin) n_state = bra_pkg::S_DONE;
            end
            bra_pkg::S_SET_RD: n_state = bra_pkg::S_SET_WR;
            bra_pkg::S_SET_WR: n_state = bra_pkg::S_DONE;
            bra_pkg::S_DONE: begin
                if (w_slot_free) n_state = bra_pkg::S_IDLE;
            end
            default: n_state = bra_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_op        = r_op;
        n_bucket    = r_bucket;
        n_nst       = r_nst;
        n_hint      = r_hint;
        n_addr      = r_addr;
        n_end       = r_end;
        n_cnt       = r_cnt;
        n_pend      = 1'b0;
        n_pidx      = r_addr[IW-1:0];
        n_cur_s     = r_cur_s;
        n_cur_l     = r_cur_l;
        n_best_s    = r_best_s;
        n_best_l    = r_best_l;
        n_rs        = r_rs;
        n_rl        = r_rl;
        n_total     = r_total;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_start   = r_o_start;
        n_o_len     = r_o_len;
        n_o_done    = r_o_done;
        n_o_all     = r_o_all;
        mem_we      = 1'b0;
        mem_waddr   = r_addr[IW-1:0];
        mem_wdata   = bra_pkg::ST_FREE;
        mem_raddr   = r_addr[IW-1:0];

        unique case (r_state)
            // clear every bucket after reset
            bra_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                n_addr = r_addr + CW'(1);
            end
            // latch the request and set up the walk
            bra_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_op     = i_op;
                    n_bucket = i_bucket;
                    n_nst    = i_new_state;
                    n_hint   = i_length_hint;
                    n_addr   = {1'b0, i_bucket};
                    n_cur_s  = '0;
                    n_cur_l  = '0;
                    n_best_s = '0;
                    n_best_l = '0;
                    n_rs     = '0;
                    n_rl     = '0;
                    n_cnt    = '0;
                    if (i_op == bra_pkg::OP_ALLOC) n_addr = '0;
                    if (i_bucket > i_range_last) begin
                        n_end = {1'b0, i_bucket};
                    end else begin
                        n_end = (w_last_p1 < w_used) ? w_last_p1 : w_used;
                    end
                end
            end
            // one bucket per cycle: read ahead, track current and best free run
            bra_pkg::S_SCAN: begin
                if (w_scan_issue) begin
                    n_pend = 1'b1;
                    n_addr = r_addr + CW'(1);
                end
                if (r_pend) begin
                    if (w_free) begin
                        n_cur_l = w_cur_l_inc;
                        if (r_cur_l == '0) n_cur_s = r_pidx;
                        if (w_better) begin
                            n_best_l = w_cur_l_inc;
                            n_best_s = (r_cur_l == '0) ? r_pidx : r_cur_s;
                        end
                    end else begin
                        n_cur_l = '0;
                    end
                end
                if (w_hit) begin
                    n_rs   = (r_cur_l == '0) ? r_pidx : r_cur_s;
                    n_rl   = w_cur_l_inc;
                    n_addr = {1'b0, n_rs};
                    n_cnt  = w_cur_l_inc;
                end else if (w_scan_fin) begin
                    n_rs   = (r_best_l == '0) ? '0 : r_best_s;
                    n_rl   = r_best_l;
                    n_addr = {1'b0, n_rs};
                    n_cnt  = r_best_l;
                end
            end
            // mark the chosen run downloading
            bra_pkg::S_MARK: begin
                if (r_cnt != '0) begin
                    mem_we    = 1'b1;
                    mem_wdata = bra_pkg::ST_DOWNLOADING;
                    n_addr    = r_addr + CW'(1);
                    n_cnt     = r_cnt - CW'(1);
                end
            end
            // read ahead, free each downloading bucket in the range
            bra_pkg::S_REL: begin
                if (w_rel_issue) begin
                    n_pend = 1'b1;
                    n_addr = r_addr + CW'(1);
                end
                if (r_pend && (r_rdata == bra_pkg::ST_DOWNLOADING)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pidx;
                    mem_wdata = bra_pkg::ST_FREE;
                end
            end
            // read old state of the bucket
            bra_pkg::S_SET_RD: begin
                mem_raddr = r_bucket;
            end
            // write new state and adjust the downloaded count
            bra_pkg::S_SET_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_bucket;
                mem_wdata = r_nst;
                n_total   = r_total
                            - CW'(r_rdata == bra_pkg::ST_DOWNLOADED)
                            + CW'(r_nst == bra_pkg::ST_DOWNLOADED);
            end
            // load the result register
            bra_pkg::S_DONE: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_o_start   = (r_op == bra_pkg::OP_ALLOC) ? r_rs : '0;
                    n_o_len     = (r_op == bra_pkg::OP_ALLOC) ? r_rl : '0;
                    n_o_done    = r_total;
                    n_o_all     = (r_total == w_used);
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= bra_pkg::S_CLEAR;
            r_addr         <= '0;
            r_pend         <= 1'b0;
            r_total        <= '0;
            r_out_valid    <= 1'b0;
            r_bucket_count <= CW'(1);
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) r_bucket_count <= i_cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_bucket  <= n_bucket;
        r_nst     <= n_nst;
        r_hint    <= n_hint;
        r_end     <= n_end;
        r_cnt     <= n_cnt;
        r_pidx    <= n_pidx;
        r_cur_s   <= n_cur_s;
        r_cur_l   <= n_cur_l;
        r_best_s  <= n_best_s;
        r_best_l  <= n_best_l;
        r_rs      <= n_rs;
        r_rl      <= n_rl;
        r_o_start <= n_o_start;
        r_o_len   <= n_o_len;
        r_o_done  <= n_o_done;
        r_o_all   <= n_o_all;
    end

    // state memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[mem_raddr];
    end

    assign o_out_valid  = r_out_valid;
    assign o_run_start  = r_o_start;
    assign o_run_length = r_o_len;
    assign o_done_count = r_o_done;
    assign o_all_done   = r_o_all;

endmodule
